>>> src/rmct_pkg.sv
package rmct_pkg;

   localparam int ElemCount  = 1024;
   localparam int IdxWidth   = 10;
   localparam int NodeWidth  = IdxWidth + 1;
   localparam int NodeTotal  = 2 * ElemCount;
   localparam int ValWidth   = 32;
   localparam int CntWidth   = 11;
   localparam int EntryWidth = ValWidth + CntWidth;

   localparam logic [1:0] STATUS_UPDATED = 2'd0;
   localparam logic [1:0] STATUS_ANSWER  = 2'd1;
   localparam logic [1:0] STATUS_INVALID = 2'd2;

   localparam logic ACTION_UPDATE = 1'b0;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPD_READ,
      ST_UPD_WAIT,
      ST_UPD_WRITE,
      ST_Q_STEP,
      ST_Q_WAIT,
      ST_Q_MERGE,
      ST_Q_SECOND,
      ST_RESP
   } state_type;

   // Node count at reset equals the number of leaves below the node.
   function automatic logic [CntWidth-1:0] span_of(input logic [NodeWidth-1:0] node);
      logic [CntWidth-1:0] span;
      span = CntWidth'(1);
      for (int b = NodeWidth - 1; b >= 0; b--) begin
         if (node[b]) begin
            span = CntWidth'(1) << (NodeWidth - 1 - b);
            break;
         end
      end
      return span;
   endfunction

endpackage

>>> src/rmct_ram.sv
module rmct_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

>>> src/range_max_count_tree.sv
// Range maximum with occurrence count over up to 1024 signed 32-bit elements,
// held as a bottom-up segment tree in one single-port-read memory. An update
// (action 0) writes one leaf and walks ten ancestors, each reading its sibling
// and writing the parent. A query (action 1) visits at most two nodes per
// level, each a memory read and a merge in the shared compare unit. The single
// memory read port makes these reads run one after another. After reset the
// block clears all 2048 tree nodes and accepts no request meanwhile. Invalid
// indices give status 2.
module range_max_count_tree
   import rmct_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: action[0], range_low[10:1], range_high[20:11], new_value[52:21], zero fill
   input  logic [55:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: status[1:0], max_value[33:2], max_count[44:34], zero fill
   output logic [47:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [10:0] csr_data
);

   state_type state_ff, state_in;
   logic [CntWidth-1:0]  count_ff, count_in;
   logic [NodeWidth:0]   node_ff, node_in;   // update walk node / query left, one bit more
   logic [NodeWidth:0]   right_ff, right_in; // query right bound, one bit more
   logic                 have_ff, have_in;
   logic [ValWidth-1:0]  best_ff, best_in;
   logic [CntWidth-1:0]  cnt_ff, cnt_in;
   logic [1:0]           status_ff, status_in;
   logic                 out_valid_ff, out_valid_in;
   logic                 pend_right_ff, pend_right_in;

   logic                   wr_en;
   logic [NodeWidth-1:0]   wr_addr, rd_addr;
   logic [EntryWidth-1:0]  wr_data, rd_data;

   rmct_ram #(.Width(EntryWidth), .Depth(NodeTotal)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Request fields.
   logic                 req_action;
   logic [IdxWidth-1:0]  req_low, req_high;
   logic [ValWidth-1:0]  req_value;
   logic [CntWidth-1:0]  eff_count;
   assign req_action = req_tdata[0];
   assign req_low    = req_tdata[10:1];
   assign req_high   = req_tdata[20:11];
   assign req_value  = req_tdata[52:21];
   assign eff_count  = (count_ff > CntWidth'(ElemCount)) ? CntWidth'(ElemCount) : count_ff;

   // Shared merge unit: accumulator against the memory word.
   logic signed [ValWidth-1:0] m_a, m_b;
   logic [CntWidth-1:0]        c_a, c_b, m_cnt;
   logic [ValWidth-1:0]        m_val;
   always_comb begin
      m_b = rd_data[EntryWidth-1:CntWidth];
      c_b = rd_data[CntWidth-1:0];
      m_val = m_b;
      m_cnt = c_b;
      if (state_ff == ST_UPD_WRITE) begin
         m_a = signed'(best_ff);
         c_a = cnt_ff;
      end else begin
         m_a = signed'(best_ff);
         c_a = cnt_ff;
      end
      if (state_ff == ST_UPD_WRITE || have_ff) begin
         if (m_a > m_b) begin
            m_val = m_a;
            m_cnt = c_a;
         end else if (m_a == m_b) begin
            m_val = m_a;
            m_cnt = c_a + c_b;
         end
      end
   end

   assign req_tready = (state_ff == ST_IDLE) && !out_valid_ff;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, cnt_ff, best_ff, status_ff};

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      count_in      = csr_valid ? csr_data : count_ff;
      node_in       = node_ff;
      right_in      = right_ff;
      have_in       = have_ff;
      best_in       = best_ff;
      cnt_in        = cnt_ff;
      status_in     = status_ff;
      pend_right_in = pend_right_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      wr_en   = 1'b0;
      wr_addr = node_ff[NodeWidth-1:0];
      wr_data = {best_ff, cnt_ff};
      rd_addr = node_ff[NodeWidth-1:0];
      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_data = {{ValWidth{1'b0}},
                       (node_ff == '0) ? CntWidth'(0) : span_of(node_ff[NodeWidth-1:0])};
            node_in = node_ff + 1'b1;
            if (node_ff[NodeWidth-1:0] == '1) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               best_in = '0;
               cnt_in  = '0;
               have_in = 1'b0;
               if (req_action == ACTION_UPDATE) begin
                  if (CntWidth'(req_low) >= eff_count) begin
                     status_in = STATUS_INVALID;
                     state_in  = ST_RESP;
                  end else begin
                     node_in   = {2'b01, req_low};
                     best_in   = req_value;
                     cnt_in    = CntWidth'(1);
                     status_in = STATUS_UPDATED;
                     state_in  = ST_UPD_READ;
                  end
               end else if (req_low > req_high || CntWidth'(req_high) >= eff_count) begin
                  status_in = STATUS_INVALID;
                  state_in  = ST_RESP;
               end else begin
                  node_in   = {2'b01, req_low};
                  right_in  = {1'b0, 1'b1, req_high} + 1'b1;
                  status_in = STATUS_ANSWER;
                  state_in  = ST_Q_STEP;
               end
            end
         end
         // Write the current node, read its sibling.
         ST_UPD_READ: begin
            wr_en   = 1'b1;
            rd_addr = node_ff[NodeWidth-1:0] ^ NodeWidth'(1);
            if (node_ff == (NodeWidth + 1)'(1)) begin
               best_in  = '0;
               cnt_in   = '0;
               state_in = ST_RESP;
            end else begin
               state_in = ST_UPD_WAIT;
            end
         end
         // Keep the sibling address so the read data stays in place.
         ST_UPD_WAIT: begin
            rd_addr  = node_ff[NodeWidth-1:0] ^ NodeWidth'(1);
            state_in = ST_UPD_WRITE;
         end
         // Merge with the sibling and move to the parent.
         ST_UPD_WRITE: begin
            best_in  = m_val;
            cnt_in   = m_cnt;
            node_in  = node_ff >> 1;
            state_in = ST_UPD_READ;
         end
         // One tree level of the query loop.
         ST_Q_STEP: begin
            if (node_ff >= right_ff) begin
               state_in = ST_RESP;
            end else if (node_ff[0]) begin
               rd_addr       = node_ff[NodeWidth-1:0];
               pend_right_in = 1'b0;
               state_in      = ST_Q_WAIT;
            end else begin
               state_in = ST_Q_SECOND;
            end
         end
         // Hold the address of the node being read.
         ST_Q_WAIT: begin
            rd_addr  = pend_right_ff ? (right_ff[NodeWidth-1:0] - 1'b1)
                                     : node_ff[NodeWidth-1:0];
            state_in = ST_Q_MERGE;
         end
         ST_Q_MERGE: begin
            best_in = m_val;
            cnt_in  = m_cnt;
            have_in = 1'b1;
            if (pend_right_ff) begin
               node_in  = node_ff >> 1;
               right_in = (right_ff - 1'b1) >> 1;
               state_in = ST_Q_STEP;
            end else begin
               node_in  = node_ff + 1'b1;
               state_in = ST_Q_SECOND;
            end
         end
         ST_Q_SECOND: begin
            if (right_ff[0]) begin
               rd_addr       = right_ff[NodeWidth-1:0] - 1'b1;
               pend_right_in = 1'b1;
               state_in      = ST_Q_WAIT;
            end else begin
               node_in  = node_ff >> 1;
               right_in = right_ff >> 1;
               state_in = ST_Q_STEP;
            end
         end
         ST_RESP: begin
            if (!out_valid_ff) begin
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         count_ff      <= CntWidth'(ElemCount);
         node_ff       <= '0;
         out_valid_ff  <= 1'b0;
         have_ff       <= 1'b0;
         pend_right_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         node_ff       <= node_in;
         out_valid_ff  <= out_valid_in;
         have_ff       <= have_in;
         pend_right_ff <= pend_right_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      right_ff  <= right_in;
      best_ff   <= best_in;
      cnt_ff    <= cnt_in;
      status_ff <= status_in;
   end

endmodule

>>> bench/range_max_checker.sv
`timescale 1ns / 1ps

// Watches the request, response and register channels, keeps a shadow array
// of the elements and predicts every response.
module range_max_checker
   import rmct_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [55:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [10:0] csr_data,
   output int          fail_count,
   output int          pending
);

   typedef struct packed {
      logic [1:0]          status;
      logic [ValWidth-1:0] max_value;
      logic [CntWidth-1:0] max_count;
   } answer_type;

   logic signed [ValWidth-1:0] shadow_elem [ElemCount];
   logic [10:0] elem_limit;
   answer_type answer_q[$];

   // Records one mismatch.
   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   // Computes the response for one request and applies any element write.
   function automatic answer_type predict_answer(input logic [55:0] d);
      answer_type a;
      logic act;
      logic [9:0] lo, hi;
      int n;
      logic signed [ValWidth-1:0] best;
      int cnt;
      a = '{STATUS_INVALID, '0, '0};
      act = d[0];
      lo = d[10:1];
      hi = d[20:11];
      n = (elem_limit > ElemCount) ? ElemCount : int'(elem_limit);
      if (act == ACTION_UPDATE) begin
         if (int'(lo) < n) begin
            shadow_elem[lo] = d[52:21];
            a.status = STATUS_UPDATED;
         end
      end else if (lo <= hi && int'(hi) < n) begin
         best = shadow_elem[lo];
         cnt = 0;
         for (int i = lo; i <= hi; i++) begin
            if (shadow_elem[i] > best) begin
               best = shadow_elem[i];
               cnt = 1;
            end else if (shadow_elem[i] == best) begin
               cnt++;
            end
         end
         a.status = STATUS_ANSWER;
         a.max_value = best;
         a.max_count = CntWidth'(cnt);
      end
      return a;
   endfunction

   always_ff @(posedge clock) begin
      answer_type want, got;
      if (reset) begin
         for (int i = 0; i < ElemCount; i++) shadow_elem[i] = '0;
         elem_limit = 11'd1024;
         answer_q.delete();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) elem_limit = csr_data;
         if (req_tvalid && req_tready) answer_q.push_back(predict_answer(req_tdata));
         // Compare each response transfer with the oldest expectation.
         if (rsp_tvalid && rsp_tready) begin
            got = answer_type'({rsp_tdata[1:0], rsp_tdata[33:2], rsp_tdata[44:34]});
            if (answer_q.size() == 0) begin
               report("unexpected response", rsp_tdata, 0);
            end else begin
               want = answer_q.pop_front();
               if (got.status !== want.status) report("status", got.status, want.status);
               if (got.max_value !== want.max_value)
                  report("max_value", got.max_value, want.max_value);
               if (got.max_count !== want.max_count)
                  report("max_count", got.max_count, want.max_count);
            end
         end
      end
      pending = answer_q.size();
   end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [10:0] csr_data = '0;
   int          fail_count;
   int          pending;
   int          cycle_count = 0;
   int          active_count = 1024;

   range_max_count_tree uut (.*);

   range_max_checker checker_inst (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   // Overall limit on run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 600000) begin
         $display("[range_max_count_tree] ERROR");
         $finish;
      end
   end

   // Response side stalls a random number of cycles per transfer; with no
   // stall the ready line simply stays high.
   initial begin
      int gap;
      forever begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // Valid stays high after a transfer until the next gap or a drain.
   task automatic send_request(input logic act, input int lo, input int hi,
                               input logic [31:0] value);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {3'b000, value, 10'(hi), 10'(lo), act};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Waits until every response is back, then lets the block settle.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_limit(input logic [10:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      active_count = (value > 1024) ? 1024 : int'(value);
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'($urandom_range(0, 3)) - 32'd1;
         default: return $urandom();
      endcase
   endfunction

   // Mostly updates and queries inside the active range, some out of it.
   task automatic random_phase(input int items);
      int lo, hi, top;
      logic act;
      for (int i = 0; i < items; i++) begin
         act = 1'($urandom_range(0, 1));
         top = (active_count == 0) ? 0 : active_count - 1;
         if ($urandom_range(0, 9) == 0) begin
            lo = int'($urandom_range(0, 1023));
            hi = int'($urandom_range(0, 1023));
         end else begin
            lo = int'($urandom_range(0, top));
            hi = (top - lo > 40 && $urandom_range(0, 4) != 0) ?
                 lo + int'($urandom_range(0, 40)) : int'($urandom_range(lo, top));
         end
         send_request(act, lo, hi, pick_value());
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      // Directed checks on the reset contents and field extremes.
      send_request(1'b1, 0, 1023, 32'h0);
      send_request(1'b1, 5, 5, 32'hffff_ffff);
      send_request(1'b0, 0, 0, 32'h7fff_ffff);
      send_request(1'b0, 1023, 1023, 32'h8000_0000);
      send_request(1'b0, 512, 0, 32'h7fff_ffff);
      send_request(1'b1, 0, 1023, 32'h0);
      send_request(1'b1, 1023, 1023, 32'h0);
      send_request(1'b1, 10, 9, 32'h0);
      send_request(1'b1, 1, 1022, 32'h0);
      send_request(1'b0, 512, 0, 32'h0);
      send_request(1'b1, 0, 1023, 32'h0);
      send_request(1'b0, 3, 1023, 32'h5555_aaaa);
      send_request(1'b1, 0, 700, 32'haaaa_5555);
      random_phase(200);
      // Zero count rejects everything.
      write_limit(11'd0);
      send_request(1'b0, 0, 0, 32'h1);
      send_request(1'b1, 0, 0, 32'h0);
      write_limit(11'd1);
      random_phase(20);
      write_limit(11'd2047);
      send_request(1'b1, 0, 1023, 32'h0);
      random_phase(150);
      write_limit(11'd37);
      random_phase(150);
      write_limit(11'd1025);
      random_phase(60);
      write_limit(11'd1024);
      random_phase(100);
      drain();
      if (fail_count == 0) begin
         $display("[range_max_count_tree] OK");
      end else begin
         $display("[range_max_count_tree] ERROR");
      end
      $finish;
   end

endmodule

>>> filelist.f
src/rmct_pkg.sv
src/rmct_ram.sv
src/range_max_count_tree.sv
bench/range_max_checker.sv
bench/testbench.sv
